### rtl/wp_pkg.sv
// shared types, tables and byte functions for the whirlpool compression core
`timescale 1ns / 1ps
package wp_pkg;

	localparam int ROUNDS = 10;
	localparam int RND_W = $clog2(ROUNDS + 1);
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef struct packed {
		logic [63:0] block_word;
		logic        start_message;
	} item_t;

	typedef struct packed {
		logic [63:0] hash_word;
		logic        last_word;
	} result_t;

	// per-cycle control for the byte-serial mix accumulator
	typedef struct packed {
		logic       first;
		logic       rc_en;
		logic [2:0] pos;
	} mix_ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} state_t;

	localparam logic [3:0] NIB_E [16] = '{
		4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
		4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
	localparam logic [3:0] NIB_E_INV [16] = '{
		4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
		4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
	localparam logic [3:0] NIB_R [16] = '{
		4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
		4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
	localparam logic [3:0] MDS_ROW [8] = '{4'd1, 4'd1, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2, 4'd9};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] r;
		a = NIB_E[x[7:4]];
		b = NIB_E_INV[x[3:0]];
		r = NIB_R[a ^ b];
		return {NIB_E[a ^ r], NIB_E_INV[b ^ r]};
	endfunction

	// multiply in gf(2^8) mod x^8+x^4+x^3+x^2+1 by a 4-bit coefficient
	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] c);
		logic [7:0] acc;
		logic [7:0] v;
		acc = 8'h00;
		v = x;
		for (int k = 0; k < 4; k++) begin
			if (c[k]) begin
				acc = acc ^ v;
			end
			v = v[7] ? ({v[6:0], 1'b0} ^ 8'h1D) : {v[6:0], 1'b0};
		end
		return acc & BYTE_MASK;
	endfunction

	function automatic logic [63:0] mix_entry(input logic [7:0] x, input logic [2:0] pos);
		logic [7:0]   s;
		logic [63:0]  v;
		logic [127:0] dbl;
		s = sbox(x);
		v = '0;
		for (int k = 0; k < 8; k++) begin
			v[63 - 8 * k -: 8] = gf_mul(s, MDS_ROW[k]);
		end
		dbl = {v, v} >> {pos, 3'b000};
		return dbl[63:0];
	endfunction

endpackage

### rtl/wp_mix_acc.sv
// byte-serial accumulator of s-box/mix contributions for key and state rows
`timescale 1ns / 1ps
module wp_mix_acc import wp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  mix_ctrl_t   ctrl,
	input  logic [7:0]  key_byte,
	input  logic [7:0]  state_byte,
	input  logic [7:0]  rc_index,
	output logic [63:0] key_sum,
	output logic [63:0] state_sum
);

	logic [63:0] key_acc_q;
	logic [63:0] state_acc_q;
	logic [63:0] rc_term;

	always_comb begin
		rc_term = '0;
		if (ctrl.rc_en) begin
			rc_term = {sbox(rc_index), 56'd0} >> {ctrl.pos, 3'b000};
		end
		key_sum = (ctrl.first ? 64'd0 : key_acc_q) ^ mix_entry(key_byte, ctrl.pos) ^ rc_term;
		state_sum = (ctrl.first ? 64'd0 : state_acc_q) ^ mix_entry(state_byte, ctrl.pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_acc_q <= '0;
			state_acc_q <= '0;
		end else if (en) begin
			key_acc_q <= key_sum;
			state_acc_q <= state_sum;
		end
	end

endmodule

### rtl/whirlpool_compression_core.sv
// top level: block load, byte-serial round sequencer and feed-forward output
`timescale 1ns / 1ps
// A block is eight transactions on start/item, one word per cycle while busy is low. The
// eighth word starts the cipher: in each of the 10 rounds one byte of the key and one byte
// of the cipher state pass through the s-box/mix unit per cycle, and busy stays high through
// the rounds and the output phase. The eight chaining words then appear on result with
// result_valid high for one cycle each, word 0 first; they cannot be held off, so the
// receiver must take every result as it comes. start_message counts only on the first
// word of a block.
module whirlpool_compression_core import wp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	state_t      state_q, state_nxt;
	logic [63:0] cv_q [8];
	logic [63:0] msg_q [8];
	logic [63:0] key_q [8];
	logic [63:0] cs_q [8];
	logic [63:0] nkey_q [8];
	logic [63:0] ncs_q [8];
	logic [2:0]  word_cnt_q;
	logic [2:0]  row_q;
	logic [2:0]  col_q;
	logic [2:0]  out_q;
	logic [RND_W-1:0] rnd_q;
	logic        result_valid_q;
	result_t     result_q;

	logic        accept;
	logic        round_en;
	logic        out_en;
	mix_ctrl_t   ctrl;
	logic [2:0]  src_row;
	logic [7:0]  rc_index;
	logic [63:0] key_sum;
	logic [63:0] state_sum;
	logic [63:0] new_key_row;
	logic [63:0] new_cs_row;
	logic [63:0] fwd_word;

	assign accept = start && !busy;
	assign src_row = row_q - col_q;
	assign ctrl.first = (col_q == 3'd0);
	assign ctrl.rc_en = (row_q == 3'd0);
	assign ctrl.pos = col_q;
	assign rc_index = 8'({rnd_q - RND_W'(1), 3'b000}) | {5'd0, col_q};
	assign new_key_row = key_sum;
	assign new_cs_row = state_sum ^ key_sum;
	assign fwd_word = cv_q[out_q] ^ cs_q[out_q] ^ msg_q[out_q];

	wp_mix_acc u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (round_en),
		.ctrl       (ctrl),
		.key_byte   (key_q[src_row][63 - 8 * col_q -: 8]),
		.state_byte (cs_q[src_row][63 - 8 * col_q -: 8]),
		.rc_index   (rc_index),
		.key_sum    (key_sum),
		.state_sum  (state_sum)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && word_cnt_q == 3'd7) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (row_q == 3'd7 && col_q == 3'd7 && rnd_q == RND_W'(ROUNDS)) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_q == 3'd7) begin
					state_nxt = ST_LOAD;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		round_en = 1'b0;
		out_en = 1'b0;
		case (state_q)
			ST_LOAD:  busy = 1'b0;
			ST_ROUND: round_en = 1'b1;
			ST_OUT:   out_en = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			word_cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			out_q <= '0;
			rnd_q <= RND_W'(1);
			result_valid_q <= 1'b0;
			for (int k = 0; k < 8; k++) begin
				cv_q[k] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			result_valid_q <= out_en;
			if (accept) begin
				word_cnt_q <= word_cnt_q + 3'd1;
				if (word_cnt_q == 3'd0 && item.start_message) begin
					for (int k = 0; k < 8; k++) begin
						cv_q[k] <= '0;
					end
				end
			end
			if (round_en) begin
				col_q <= col_q + 3'd1;
				if (col_q == 3'd7) begin
					row_q <= row_q + 3'd1;
					if (row_q == 3'd7) begin
						rnd_q <= (rnd_q == RND_W'(ROUNDS)) ? RND_W'(1) : rnd_q + RND_W'(1);
					end
				end
			end
			if (out_en) begin
				out_q <= out_q + 3'd1;
				cv_q[out_q] <= fwd_word;
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			msg_q[word_cnt_q] <= item.block_word;
			if (word_cnt_q == 3'd7) begin
				// key is the chaining value, state is message xor key
				for (int k = 0; k < 8; k++) begin
					key_q[k] <= cv_q[k];
					cs_q[k] <= ((k == 7) ? item.block_word : msg_q[k]) ^ cv_q[k];
				end
			end
		end
		if (round_en && col_q == 3'd7) begin
			nkey_q[row_q] <= new_key_row;
			ncs_q[row_q] <= new_cs_row;
			if (row_q == 3'd7) begin
				for (int k = 0; k < 7; k++) begin
					key_q[k] <= nkey_q[k];
					cs_q[k] <= ncs_q[k];
				end
				key_q[7] <= new_key_row;
				cs_q[7] <= new_cs_row;
			end
		end
		if (out_en) begin
			result_q.hash_word <= fwd_word;
			result_q.last_word <= (out_q == 3'd7);
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
